/* rtl/pngp_pkg.sv */
package pngp_pkg;

  typedef enum logic [1:0] {
    KIND_PAL  = 2'd0,
    KIND_SUM  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE  = 4'd0,
    ERR_SIG   = 4'd1,
    ERR_ORDER = 4'd2,
    ERR_ILEN  = 4'd3,
    ERR_IHDR  = 4'd4,
    ERR_PLTE  = 4'd5,
    ERR_PHYS  = 4'd6,
    ERR_NOPAL = 4'd7,
    ERR_COLOR = 4'd8,
    ERR_TRUNC = 4'd9
  } err_e;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HDR  = 3'd1,
    PH_IHDR = 3'd2,
    PH_PLTE = 3'd3,
    PH_PHYS = 3'd4,
    PH_SKIP = 3'd5,
    PH_DONE = 3'd6
  } phase_e;

  localparam logic [31:0] T_IHDR = 32'h4948_4452;
  localparam logic [31:0] T_PLTE = 32'h504C_5445;
  localparam logic [31:0] T_PHYS = 32'h7048_5973;
  localparam logic [31:0] T_IDAT = 32'h4944_4154;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [3:0]  bit_depth;
    logic [7:0]  color_type;
    logic [8:0]  palette_count;
    logic [31:0] x_density;
    logic [31:0] y_density;
    logic [7:0]  density_unit;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  // value mod 3: base-4 digits sum to the same residue since 4 = 1 mod 3
  function automatic logic [1:0] mod3_10(input logic [9:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [1:0] m;
    s1 = {2'b0, v[9:8]} + {2'b0, v[7:6]} + {2'b0, v[5:4]} + {2'b0, v[3:2]}
         + {2'b0, v[1:0]};
    s2 = {1'b0, s1[3:2]} + {1'b0, s1[1:0]};
    unique case (s2)
      3'd0, 3'd3, 3'd6: m = 2'd0;
      3'd1, 3'd4:       m = 2'd1;
      3'd2, 3'd5:       m = 2'd2;
      default:          m = 2'd0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/png_chunk_header_parser.sv */
// Results are registered in the result queue before they reach the output ports.
// Throughput: one byte per cycle; the parser stalls whenever the two-entry result
// queue is full, even when the consumer holds ready high.
// Reset: asynchronous active low; the parser waits for the PNG signature and the
// result queue is empty.
module png_chunk_header_parser #(
  parameter int unsigned MAX_PALETTE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  input  logic        file_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  error_code_o,
  output logic [7:0]  palette_index_o,
  output logic [23:0] palette_rgb_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o,
  output logic [3:0]  bit_depth_o,
  output logic [7:0]  color_type_o,
  output logic [8:0]  palette_count_o,
  output logic [31:0] x_density_o,
  output logic [31:0] y_density_o,
  output logic [7:0]  density_unit_o
);
  import pngp_pkg::*;

  // Front end parses bytes; every transfer that yields a result pushes it to the queue.
  logic    res_valid, res_ready;
  result_t res, outr;

  pngp_front #(.MaxPalette(MAX_PALETTE)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .data_byte_i, .file_start_i, .file_end_i,
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  // Queue decouples the parser from the consumer.
  pngp_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(res_valid), .in_ready_o(res_ready), .in_data_i(res),
    .out_valid_o, .out_ready_i, .out_data_o(outr)
  );

  assign kind_o          = outr.kind;
  assign error_code_o    = outr.error_code;
  assign palette_index_o = outr.palette_index;
  assign palette_rgb_o   = outr.palette_rgb;
  assign image_width_o   = outr.image_width;
  assign image_height_o  = outr.image_height;
  assign bit_depth_o     = outr.bit_depth;
  assign color_type_o    = outr.color_type;
  assign palette_count_o = outr.palette_count;
  assign x_density_o     = outr.x_density;
  assign y_density_o     = outr.y_density;
  assign density_unit_o  = outr.density_unit;
endmodule

/* rtl/pngp_front.sv */
module pngp_front #(
  parameter int unsigned MaxPalette = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             file_start_i,
  input  logic             file_end_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output pngp_pkg::result_t res_o
);
  import pngp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [32:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] typ_q, typ_d;
  logic [2:0]  seen_q, seen_d;
  logic [31:0] wid_q, wid_d, hgt_q, hgt_d, xd_q, xd_d, yd_q, yd_d;
  logic [7:0]  dep_q, dep_d, col_q, col_d, unit_q, unit_d;
  logic [8:0]  ent_q, ent_d;
  logic [15:0] part_q, part_d;
  logic [1:0]  mod3_q, mod3_d;

  logic        go;
  logic        emit;
  result_t     r;
  phase_e      ph;
  logic [32:0] ci;
  logic [2:0]  sn;
  logic [7:0]  cl;
  logic [8:0]  en;
  logic [31:0] hl, ht;

  assign ready_o = res_ready_i;
  assign go = valid_i && ready_o;
  assign res_valid_o = go && emit;
  assign res_o = r;

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; len_d = len_q; typ_d = typ_q; seen_d = seen_q;
    wid_d = wid_q; hgt_d = hgt_q; xd_d = xd_q; yd_d = yd_q; dep_d = dep_q;
    col_d = col_q; unit_d = unit_q; ent_d = ent_q; part_d = part_q; mod3_d = mod3_q;
    emit = 1'b0;
    r = '0;
    if (file_start_i) begin
      phase_d = PH_SIG; cnt_d = '0; len_d = '0; typ_d = '0; seen_d = '0;
      wid_d = '0; hgt_d = '0; dep_d = '0; col_d = '0; xd_d = 32'd1; yd_d = 32'd1;
      unit_d = '0; ent_d = '0; part_d = '0; mod3_d = '0;
    end
    ph = phase_d; ci = cnt_d; sn = seen_d; cl = col_d; en = ent_d;
    hl = len_d; ht = typ_d;
    unique case (ph)
      PH_SIG: begin
        if (data_byte_i != sig_byte(ci[2:0])) begin
          emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_SIG; phase_d = PH_DONE;
        end else if (ci == 33'd7) begin
          cnt_d = '0; phase_d = PH_HDR;
        end else cnt_d = ci + 33'd1;
      end
      PH_HDR: begin
        if (ci < 33'd4) begin
          hl = {len_d[23:0], data_byte_i}; len_d = hl;
        end else begin
          ht = {typ_d[23:0], data_byte_i}; typ_d = ht;
        end
        cnt_d = ci + 33'd1;
        if (ci == 33'd7) begin
          cnt_d = '0; mod3_d = '0;
          if (ht == T_IHDR) begin
            if (sn[0]) begin
              emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_ORDER;
              phase_d = PH_DONE;
            end else if (hl != 32'd13) begin
              emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_ILEN;
              phase_d = PH_DONE;
            end else begin
              seen_d[0] = 1'b1; phase_d = PH_IHDR;
            end
          end else if (!sn[0]) begin
            emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_ORDER; phase_d = PH_DONE;
          end else if (ht == T_PLTE) begin
            // low bits suffice: anything above the palette limit fails anyway
            if (sn[1] || hl > 32'(3 * MaxPalette) || mod3_10(hl[9:0]) != 2'd0
                || cl == 8'd0) begin
              emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_PLTE;
              phase_d = PH_DONE;
            end else begin
              seen_d[1] = 1'b1; phase_d = PH_PLTE;
            end
          end else if (ht == T_PHYS) begin
            if (sn[2] || hl != 32'd9) begin
              emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_PHYS;
              phase_d = PH_DONE;
            end else begin
              seen_d[2] = 1'b1; phase_d = PH_PHYS;
            end
          end else if (ht == T_IDAT) begin
            emit = 1'b1; phase_d = PH_DONE;
            if (cl == 8'd3 && !sn[1]) begin
              r.kind = KIND_ERR; r.error_code = ERR_NOPAL;
            end else if (cl != 8'd0 && cl != 8'd2 && cl != 8'd3) begin
              r.kind = KIND_ERR; r.error_code = ERR_COLOR;
            end else begin
              r.kind = KIND_SUM; r.image_width = wid_d; r.image_height = hgt_d;
              r.bit_depth = dep_d[3:0]; r.color_type = cl; r.palette_count = en;
              r.x_density = xd_d; r.y_density = yd_d; r.density_unit = unit_d;
            end
          end else begin
            cnt_d = {1'b0, hl} + 33'd4; phase_d = PH_SKIP;
          end
        end
      end
      PH_IHDR: begin
        if (ci < 33'd4) wid_d = {wid_d[23:0], data_byte_i};
        else if (ci < 33'd8) hgt_d = {hgt_d[23:0], data_byte_i};
        else if (ci == 33'd8) begin
          dep_d = data_byte_i;
          if (data_byte_i > 8'd8) begin
            emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_IHDR;
            phase_d = PH_DONE;
          end
        end else if (ci == 33'd9) col_d = data_byte_i;
        else if (ci < 33'd13 && data_byte_i != 8'd0) begin
          emit = 1'b1; r.kind = KIND_ERR; r.error_code = ERR_IHDR; phase_d = PH_DONE;
        end
        if (!emit) begin
          if (ci == 33'd16) begin
            cnt_d = '0; phase_d = PH_HDR;
          end else cnt_d = ci + 33'd1;
        end
      end
      PH_PHYS: begin
        if (ci < 33'd4) xd_d = {xd_d[23:0], data_byte_i};
        else if (ci < 33'd8) yd_d = {yd_d[23:0], data_byte_i};
        else if (ci == 33'd8) unit_d = data_byte_i;
        if (ci == 33'd12) begin
          cnt_d = '0; phase_d = PH_HDR;
        end else cnt_d = ci + 33'd1;
      end
      PH_PLTE: begin
        if (ci < {1'b0, len_d}) begin
          // running i mod 3 replaces a divider
          if (mod3_q != 2'd2) begin
            part_d = {part_d[7:0], data_byte_i}; mod3_d = mod3_q + 2'd1;
          end else begin
            emit = 1'b1; r.kind = KIND_PAL; r.palette_index = en[7:0];
            r.palette_rgb = {part_d, data_byte_i};
            ent_d = en + 9'd1; part_d = '0; mod3_d = '0;
          end
        end
        if (ci + 33'd1 >= {1'b0, len_d} + 33'd4) begin
          cnt_d = '0; phase_d = PH_HDR;
        end else cnt_d = ci + 33'd1;
      end
      PH_SKIP: begin
        if (ci <= 33'd1) begin
          cnt_d = '0; phase_d = PH_HDR;
        end else cnt_d = ci - 33'd1;
      end
      default: ;
    endcase
    if (ph != PH_DONE && !emit && file_end_i && phase_d != PH_DONE) begin
      emit = 1'b1; r = '0; r.kind = KIND_ERR; r.error_code = ERR_TRUNC; phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG; cnt_q <= '0; len_q <= '0; typ_q <= '0; seen_q <= '0;
      wid_q <= '0; hgt_q <= '0; dep_q <= '0; col_q <= '0;
      xd_q <= 32'd1; yd_q <= 32'd1; unit_q <= '0; ent_q <= '0; part_q <= '0;
      mod3_q <= '0;
    end else if (go) begin
      phase_q <= phase_d; cnt_q <= cnt_d; len_q <= len_d; typ_q <= typ_d;
      seen_q <= seen_d; wid_q <= wid_d; hgt_q <= hgt_d; dep_q <= dep_d;
      col_q <= col_d; xd_q <= xd_d; yd_q <= yd_d; unit_q <= unit_d;
      ent_q <= ent_d; part_q <= part_d; mod3_q <= mod3_d;
    end
  end
endmodule

/* rtl/pngp_fifo.sv */
module pngp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pngp_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pngp_pkg::result_t out_data_o
);
  import pngp_pkg::*;

  result_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

/* dv/tb_png_chunk_header_parser.sv */
`timescale 1ns / 1ps

module tb_png_chunk_header_parser;
  import pngp_pkg::*;

  localparam int unsigned MAX_PAL   = 256;
  localparam int unsigned N_ITEMS   = 1850;
  localparam int unsigned WD_LIMIT  = 2000;  // idle cycles before giving up
  localparam int unsigned HOLD_LEN  = 60;    // long consumer stall
  localparam logic [7:0]  MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                        8'h0D, 8'h0A, 8'h1A, 8'h0A};

  // Expected-result tracker: mirrors the parser and holds pending results
  class png_scoreboard;
    result_t     pending_q[$];
    int          n_errors;
    phase_e      phase;
    logic [32:0] cnt;
    logic [31:0] clen, ctype, wid, hgt, xd, yd;
    logic [7:0]  dep, col, unit;
    logic [2:0]  seen;
    logic [8:0]  entries;
    logic [15:0] partial;

    function new();
      n_errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_SIG; cnt = '0; clen = '0; ctype = '0; seen = '0;
      wid = '0; hgt = '0; dep = '0; col = '0; xd = 32'd1; yd = 32'd1;
      unit = '0; entries = '0; partial = '0;
    endfunction

    function bit fault(err_e code, output result_t r);
      r = '0;
      r.kind = KIND_ERR;
      r.error_code = code;
      phase = PH_DONE;
      return 1'b1;
    endfunction

    // chunk header complete: decide on the chunk type
    function bit header_done(output result_t r);
      r = '0;
      cnt = '0;
      if (ctype == T_IHDR) begin
        if (seen[0]) return fault(ERR_ORDER, r);
        if (clen != 32'd13) return fault(ERR_ILEN, r);
        seen[0] = 1'b1;
        phase = PH_IHDR;
        return 1'b0;
      end
      if (!seen[0]) return fault(ERR_ORDER, r);
      if (ctype == T_PLTE) begin
        if (seen[1] || clen > 3 * MAX_PAL || (clen % 3) != 0 || col == 8'd0)
          return fault(ERR_PLTE, r);
        seen[1] = 1'b1;
        phase = PH_PLTE;
        return 1'b0;
      end
      if (ctype == T_PHYS) begin
        if (seen[2] || clen != 32'd9) return fault(ERR_PHYS, r);
        seen[2] = 1'b1;
        phase = PH_PHYS;
        return 1'b0;
      end
      if (ctype == T_IDAT) begin
        if (col == 8'd3 && !seen[1]) return fault(ERR_NOPAL, r);
        if (col != 8'd0 && col != 8'd2 && col != 8'd3) return fault(ERR_COLOR, r);
        r.kind = KIND_SUM;
        r.image_width = wid;
        r.image_height = hgt;
        r.bit_depth = dep[3:0];
        r.color_type = col;
        r.palette_count = entries;
        r.x_density = xd;
        r.y_density = yd;
        r.density_unit = unit;
        phase = PH_DONE;
        return 1'b1;
      end
      cnt = {1'b0, clen} + 33'd4;   // unknown chunk: body plus CRC
      phase = PH_SKIP;
      return 1'b0;
    endfunction

    function bit parse_byte(logic [7:0] b, output result_t r);
      logic [32:0] i;
      i = cnt;
      r = '0;
      case (phase)
        PH_SIG: begin
          if (b != MAGIC[i[2:0]]) return fault(ERR_SIG, r);
          cnt = i + 1;
          if (cnt >= 8) begin cnt = '0; phase = PH_HDR; end
        end
        PH_HDR: begin
          if (i < 4) clen = {clen[23:0], b};
          else ctype = {ctype[23:0], b};
          cnt = i + 1;
          if (cnt >= 8) return header_done(r);
        end
        PH_IHDR: begin
          if (i < 4) wid = {wid[23:0], b};
          else if (i < 8) hgt = {hgt[23:0], b};
          else if (i == 8) begin
            dep = b;
            if (b > 8) return fault(ERR_IHDR, r);
          end else if (i == 9) col = b;
          else if (i < 13) begin
            if (b != 0) return fault(ERR_IHDR, r);
          end
          cnt = i + 1;
          if (cnt >= 17) begin cnt = '0; phase = PH_HDR; end
        end
        PH_PHYS: begin
          if (i < 4) xd = {xd[23:0], b};
          else if (i < 8) yd = {yd[23:0], b};
          else if (i == 8) unit = b;
          cnt = i + 1;
          if (cnt >= 13) begin cnt = '0; phase = PH_HDR; end
        end
        PH_PLTE: begin
          bit got;
          got = 1'b0;
          if (i < {1'b0, clen}) begin
            if ((i % 3) < 2) partial = {partial[7:0], b};
            else begin
              r.kind = KIND_PAL;
              r.palette_index = entries[7:0];
              r.palette_rgb = {partial, b};
              entries = entries + 1;
              partial = '0;
              got = 1'b1;
            end
          end
          cnt = i + 1;
          if (cnt >= {1'b0, clen} + 33'd4) begin cnt = '0; phase = PH_HDR; end
          return got;
        end
        PH_SKIP: begin
          if (i <= 1) begin cnt = '0; phase = PH_HDR; end
          else cnt = i - 1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    // accepted input transfer: predict and queue what it causes
    function void note_byte(logic [7:0] b, logic st, logic fe);
      result_t r;
      bit got;
      if (st) restart();
      if (phase == PH_DONE) return;
      got = parse_byte(b, r);
      if (!got && fe && phase != PH_DONE) got = fault(ERR_TRUNC, r);
      if (got) pending_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      n_errors++;
    endtask

    task check_result(result_t got);
      result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result kind", got.kind, '0);
        return;
      end
      w = pending_q.pop_front();
      if (got.kind !== w.kind) report("kind", got.kind, w.kind);
      if (got.error_code !== w.error_code) report("error_code", got.error_code, w.error_code);
      if (got.palette_index !== w.palette_index)
        report("palette_index", got.palette_index, w.palette_index);
      if (got.palette_rgb !== w.palette_rgb) report("palette_rgb", got.palette_rgb, w.palette_rgb);
      if (got.image_width !== w.image_width) report("image_width", got.image_width, w.image_width);
      if (got.image_height !== w.image_height)
        report("image_height", got.image_height, w.image_height);
      if (got.bit_depth !== w.bit_depth) report("bit_depth", got.bit_depth, w.bit_depth);
      if (got.color_type !== w.color_type) report("color_type", got.color_type, w.color_type);
      if (got.palette_count !== w.palette_count)
        report("palette_count", got.palette_count, w.palette_count);
      if (got.x_density !== w.x_density) report("x_density", got.x_density, w.x_density);
      if (got.y_density !== w.y_density) report("y_density", got.y_density, w.y_density);
      if (got.density_unit !== w.density_unit)
        report("density_unit", got.density_unit, w.density_unit);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid, in_ready;
  logic [7:0]  data_byte;
  logic        file_start, file_end;
  logic        out_valid, out_ready;
  result_t     res;

  png_scoreboard sb;
  logic [7:0]    file_q[$];   // bytes of the file being built
  int            n_sent;
  int            idle_cycles;
  bit            quiet;       // no idling in the final stretch
  bit            hold_req;    // ask the consumer for one long stall

  png_chunk_header_parser #(.MAX_PALETTE(MAX_PAL)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .file_start_i   (file_start),
    .file_end_i     (file_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (res.kind),
    .error_code_o   (res.error_code),
    .palette_index_o(res.palette_index),
    .palette_rgb_o  (res.palette_rgb),
    .image_width_o  (res.image_width),
    .image_height_o (res.image_height),
    .bit_depth_o    (res.bit_depth),
    .color_type_o   (res.color_type),
    .palette_count_o(res.palette_count),
    .x_density_o    (res.x_density),
    .y_density_o    (res.y_density),
    .density_unit_o (res.density_unit)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Monitor: inputs are predicted before outputs are checked, so a result,
  // registered in the queue before it leaves, always finds its expectation waiting.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_byte(data_byte, file_start, file_end);
      if (out_valid && out_ready) sb.check_result(res);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Consumer: short random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one transfer; valid stays up into the next byte unless a gap follows
  task automatic send_byte(logic [7:0] b, logic st, logic fe);
    in_valid   <= 1'b1;
    data_byte  <= b;
    file_start <= st;
    file_end   <= fe;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  function automatic void push32(logic [31:0] v);
    for (int k = 3; k >= 0; k--) file_q.push_back(v[8*k +: 8]);
  endfunction

  function automatic void push_rand(int n);
    for (int k = 0; k < n; k++) file_q.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed files with random content; a share carry one or more faults.
  function automatic void build_file(bit want_pal);
    logic [31:0] len;
    logic [7:0]  colour;
    int          n_chunks;
    file_q.delete();
    foreach (MAGIC[k]) file_q.push_back(MAGIC[k]);
    if ($urandom_range(0, 19) == 0)
      file_q[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 24) == 0) begin
      // foreign chunk ahead of IHDR
      push32(2); push32($urandom); push_rand(6);
    end
    for (int d = 0; d < (($urandom_range(0, 24) == 0) ? 2 : 1); d++) begin
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 20) : 13;
      push32(len);
      push32(T_IHDR);
      push32(pick_dim());
      push32(pick_dim());
      case ($urandom_range(0, 11))
        0:       file_q.push_back(8'($urandom_range(9, 255)));
        1:       file_q.push_back(8'd16);
        2:       file_q.push_back(8'd0);
        default: file_q.push_back(8'(1 << $urandom_range(0, 3)));
      endcase
      case ($urandom_range(0, 15))
        0:       colour = 8'd4;
        1:       colour = 8'd6;
        2:       colour = 8'($urandom);
        default: colour = 8'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 3));
      endcase
      if (want_pal) colour = 8'd3;
      file_q.push_back(colour);
      for (int k = 0; k < 3; k++)
        file_q.push_back(($urandom_range(0, 24) == 0) ? 8'($urandom_range(1, 255)) : 8'h0);
      push_rand(4);  // CRC, never checked
    end
    n_chunks = want_pal ? 1 : $urandom_range(0, 3);
    for (int c = 0; c < n_chunks; c++) begin
      int kind_sel;
      kind_sel = want_pal ? 0 : $urandom_range(0, 2);
      if (kind_sel == 0) begin
        if (want_pal) len = 3 * 20;
        else if ($urandom_range(0, 79) == 0) len = 3 * MAX_PAL;
        else if ($urandom_range(0, 11) == 0) len = $urandom_range(0, 800);
        else len = 3 * $urandom_range(0, 8);
        push32(len); push32(T_PLTE);
      end else if (kind_sel == 1) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 12) : 9;
        push32(len); push32(T_PHYS);
      end else begin
        len = $urandom_range(0, 6);
        push32(len); push32($urandom);
      end
      push_rand(len + 4);
    end
    push32($urandom_range(0, 50));
    push32(T_IDAT);
    push_rand($urandom_range(0, 4));
    if ($urandom_range(0, 9) == 0) file_q = file_q[0 : $urandom_range(0, file_q.size() - 1)];
  endfunction

  task automatic send_file();
    foreach (file_q[k]) send_byte(file_q[k], k == 0, k == file_q.size() - 1);
    // stray bytes after the file: ignored, or a restart with garbage
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 1));
  endtask

  initial begin
    int n_files;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid    <= 1'b0;
    data_byte   <= '0;
    file_start  <= 1'b0;
    file_end    <= 1'b0;
    n_sent      = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: signature check right after reset without a start marker,
    // a one-byte file, a bad first byte, extreme byte values while ignored
    send_byte(8'h89, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h89, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);

    n_files = 0;
    while (n_sent < N_ITEMS) begin
      // file 4 carries a palette while the consumer stalls long
      build_file(n_files == 4);
      if (n_files == 4) hold_req = 1'b1;
      if (n_sent > N_ITEMS * 85 / 100) quiet = 1'b1;
      send_file();
      n_files++;
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* png_chunk_header_parser.f */
rtl/pngp_pkg.sv
rtl/pngp_front.sv
rtl/pngp_fifo.sv
rtl/png_chunk_header_parser.sv
dv/tb_png_chunk_header_parser.sv
